// ===== rtl/core/kptt_pkg.sv =====
// ----------------------------------------------------------------------------
// kptt_pkg
// Shared types and codes of the keyed periodic timer table: command and
// result beats, the timer entry held in each cell and the cell command.
// ----------------------------------------------------------------------------
package kptt_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_key;
    logic [31:0] period_ms;
    logic [15:0] repeat_count;
    logic        multi_shot;
    logic [31:0] time_value;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [15:0] fired_key;
    logic        removed;
    logic        last;
  } out_beat_t;

  // one timer entry (valid bit kept apart)
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] last_time;
    logic [31:0] period;
    logic        multi;
    logic [15:0] count;
  } entry_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_DEL  = 3'd2,
    OP_SET  = 3'd3,
    OP_ROT  = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     add_ok;
    entry_t   new_entry;
    logic     push_valid;
    entry_t   push_entry;
  } cell_cmd_t;

endpackage

// ===== rtl/core/keyed_periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// keyed_periodic_timer_table
// Ordered table of periodic timers kept as a row of cells. Add, delete and
// set commands act on all cells at once; a tick rotates the table through
// the head unit one entry per cycle while the rotation is not stalled.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------
//   command  | in_valid_i/in_ready_o  | in_data_i  (in_beat_t)
//   result   | out_valid_o/out_ready_i| out_data_o (out_beat_t)
//
// Add, delete and set each give one status beat.
// A tick rotates the N valid entries through the head unit, one entry per
// cycle unless the rotation stalls, then the done beat follows.
// A new command is taken only in idle with the output register free.
// A full output register stalls the rotation on a firing entry.
// Reset clears the valid bits and the fill count at once; no clearing pass.
// ----------------------------------------------------------------------------
module keyed_periodic_timer_table
  import kptt_pkg::*;
#(
  parameter int Slots    = 16,
  parameter int TimeBits = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int UsedBits = $clog2(Slots + 1);
  localparam logic [31:0] TimeMask =
    (TimeBits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TimeBits) - 32'd1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TICK = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [UsedBits-1:0] used_q, used_d;
  logic [UsedBits-1:0] steps_q, steps_d;
  logic [31:0] now_q;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_data_q, out_data_d;

  logic        accept, out_free, any_match, add_ok, step_go;
  logic [31:0] tval;
  logic        fire, gone;
  entry_t      push;
  cell_cmd_t   cmd;

  logic [Slots-1:0] valid;
  logic [Slots-1:0] match;
  logic [Slots:0]   chain;
  entry_t           ent [Slots];

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign tval       = in_data_i.time_value & TimeMask;

  // key lookup over the row
  assign any_match = |match;
  assign add_ok    = (in_data_i.task_key != 16'd0) && !any_match &&
                     (used_q != UsedBits'(Slots));

  // head evaluation
  kptt_head #(
    .TimeBits(TimeBits)
  ) u_head (
    .entry_i(ent[0]),
    .now_i  (now_q),
    .fire_o (fire),
    .gone_o (gone),
    .push_o (push)
  );

  assign step_go = (state_q == S_TICK) && (steps_q != '0) && (!fire || out_free);

  // cell command
  always_comb begin
    cmd.op                  = OP_NONE;
    cmd.add_ok              = add_ok;
    cmd.new_entry.key       = in_data_i.task_key;
    cmd.new_entry.last_time = tval;
    cmd.new_entry.period    = in_data_i.period_ms;
    cmd.new_entry.multi     = in_data_i.multi_shot;
    cmd.new_entry.count     = in_data_i.repeat_count;
    cmd.push_valid          = !gone;
    cmd.push_entry          = push;
    if (accept) begin
      case (in_data_i.command)
        CMD_ADD: cmd.op = OP_ADD;
        CMD_DEL: cmd.op = OP_DEL;
        CMD_SET: cmd.op = OP_SET;
        default: cmd.op = OP_NONE;
      endcase
    end else if (step_go) begin
      cmd.op = OP_ROT;
    end
  end

  // row of cells
  assign chain[0] = 1'b0;
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    logic   prev_valid;
    logic   next_valid;
    entry_t next_entry;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_prev
      assign prev_valid = valid[i-1];
    end
    if (i == Slots - 1) begin : g_lastc
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_next
      assign next_valid = valid[i+1];
      assign next_entry = ent[i+1];
    end
    kptt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .prev_valid_i(prev_valid),
      .next_valid_i(next_valid),
      .next_entry_i(next_entry),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .match_o     (match[i]),
      .valid_o     (valid[i]),
      .entry_o     (ent[i])
    );
  end

  // sequencing, fill count and result beats
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_data_d.fired_key = 16'd0;
          out_data_d.removed   = 1'b0;
          out_data_d.last      = 1'b1;
          out_data_d.kind      = KIND_STATUS;
          case (in_data_i.command)
            CMD_ADD: begin
              out_valid_d   = 1'b1;
              out_data_d.ok = add_ok;
              if (add_ok) begin
                used_d = used_q + UsedBits'(1);
              end
            end
            CMD_DEL: begin
              out_valid_d   = 1'b1;
              out_data_d.ok = any_match;
              if (any_match) begin
                used_d = used_q - UsedBits'(1);
              end
            end
            CMD_SET: begin
              out_valid_d   = 1'b1;
              out_data_d.ok = any_match;
            end
            default: begin
              out_data_d = out_data_q;
              steps_d    = used_q;
              state_d    = S_TICK;
            end
          endcase
        end
      end
      S_TICK: begin
        if (steps_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = '{kind: KIND_DONE, ok: 1'b1, fired_key: 16'd0,
                            removed: 1'b0, last: 1'b1};
            state_d     = S_IDLE;
          end
        end else if (step_go) begin
          steps_d = steps_q - UsedBits'(1);
          if (fire) begin
            out_valid_d = 1'b1;
            out_data_d  = '{kind: KIND_FIRED, ok: 1'b1, fired_key: ent[0].key,
                            removed: gone, last: 1'b0};
            if (gone) begin
              used_d = used_q - UsedBits'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      now_q <= tval;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/kptt_cell.sv =====
// ----------------------------------------------------------------------------
// kptt_cell
// One table slot. Holds a timer entry, matches keys, and takes its
// neighbor's entry on delete compaction and on tick rotation.
// ----------------------------------------------------------------------------
module kptt_cell
  import kptt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      prev_valid_i,
  input  logic      next_valid_i,
  input  entry_t    next_entry_i,
  input  logic      chain_i,
  output logic      chain_o,
  output logic      match_o,
  output logic      valid_o,
  output entry_t    entry_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // key compare and delete prefix chain
  assign match_o = valid_q && (entry_q.key == cmd_i.new_entry.key);
  assign chain_o = chain_i | match_o;

  // next slot contents
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    unique case (cmd_i.op)
      OP_ADD: begin
        if (cmd_i.add_ok && !valid_q && prev_valid_i) begin
          valid_d = 1'b1;
          entry_d = cmd_i.new_entry;
        end
      end
      OP_DEL: begin
        if (chain_o) begin
          valid_d = next_valid_i;
          entry_d = next_entry_i;
        end
      end
      OP_SET: begin
        if (match_o) begin
          entry_d.last_time = cmd_i.new_entry.last_time;
        end
      end
      OP_ROT: begin
        if (valid_q && !next_valid_i) begin
          valid_d = cmd_i.push_valid;
          entry_d = cmd_i.push_entry;
        end else begin
          valid_d = next_valid_i;
          entry_d = next_entry_i;
        end
      end
      default: begin
      end
    endcase
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ===== rtl/core/kptt_head.sv =====
// ----------------------------------------------------------------------------
// kptt_head
// Tick evaluation of the entry at the head of the table: modular elapsed
// time against the period, count update and removal decision.
// ----------------------------------------------------------------------------
module kptt_head
  import kptt_pkg::*;
#(
  parameter int TimeBits = 32
) (
  input  entry_t      entry_i,
  input  logic [31:0] now_i,
  output logic        fire_o,
  output logic        gone_o,
  output entry_t      push_o
);

  localparam int CalcBits = (TimeBits > 32) ? TimeBits : 32;
  localparam logic [CalcBits-1:0] CalcMask =
    (TimeBits >= CalcBits) ? {CalcBits{1'b1}} : ((CalcBits'(1) << TimeBits) - CalcBits'(1));

  logic [CalcBits-1:0] elapsed;
  logic [15:0]         count_dec;

  // elapsed time modulo the time width
  assign elapsed = (CalcBits'(now_i) - CalcBits'(entry_i.last_time)) & CalcMask;
  assign fire_o  = (elapsed >= CalcBits'(entry_i.period));

  // count update
  assign count_dec = entry_i.count - 16'd1;
  assign gone_o    = fire_o && entry_i.multi && (count_dec == 16'd0);

  // entry handed back to the tail
  always_comb begin
    push_o = entry_i;
    if (fire_o) begin
      push_o.last_time = now_i;
      if (entry_i.multi) begin
        push_o.count = count_dec;
      end
    end
  end

endmodule
